// ----- hdl/atte_pkg.sv -----
// ----------------------------------------------------------------------------
// atte_pkg
// Shared sizes, byte codes and controller/datapath command types for the
// ANSI text terminal engine.
// ----------------------------------------------------------------------------
package atte_pkg;

    localparam int SCREEN_COLS = 180;
    localparam int SCREEN_ROWS = 49;
    localparam int MAX_PARAMS  = 8;

    localparam int ROW_W   = 6;
    localparam int COL_W   = 8;
    localparam int BYTE_W  = 8;
    localparam int COLOR_W = 3;
    localparam int PARAM_W = 12;
    localparam int CELL_W  = BYTE_W + COLOR_W + 1;

    localparam int CELL_COUNT = SCREEN_ROWS * SCREEN_COLS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int PC_W       = $clog2(MAX_PARAMS + 1);
    localparam int PI_W       = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

    localparam int PARAM_LIMIT = 4095;
    localparam int TAB_STOP    = 8;

    localparam logic [COLOR_W-1:0] COLOR_WHITE = 3'd7;
    localparam logic [CELL_W-1:0]  BLANK_CELL  = {1'b0, COLOR_WHITE, 8'd32};

    // control bytes
    localparam logic [BYTE_W-1:0] BYTE_ESC   = 8'd27;
    localparam logic [BYTE_W-1:0] BYTE_LF    = 8'd10;
    localparam logic [BYTE_W-1:0] BYTE_CR    = 8'd13;
    localparam logic [BYTE_W-1:0] BYTE_BS    = 8'd8;
    localparam logic [BYTE_W-1:0] BYTE_HT    = 8'd9;
    localparam logic [BYTE_W-1:0] BYTE_SPACE = 8'd32;
    localparam logic [BYTE_W-1:0] BYTE_DEL   = 8'd127;
    localparam logic [BYTE_W-1:0] BYTE_LBRK  = "[";
    localparam logic [BYTE_W-1:0] BYTE_SEMI  = ";";
    localparam logic [BYTE_W-1:0] BYTE_ZERO  = "0";
    localparam logic [BYTE_W-1:0] BYTE_NINE  = "9";

    // CSI final letters
    localparam logic [BYTE_W-1:0] CSI_CUP  = "H";
    localparam logic [BYTE_W-1:0] CSI_HVP  = "f";
    localparam logic [BYTE_W-1:0] CSI_CUU  = "A";
    localparam logic [BYTE_W-1:0] CSI_CUD  = "B";
    localparam logic [BYTE_W-1:0] CSI_CUF  = "C";
    localparam logic [BYTE_W-1:0] CSI_CUB  = "D";
    localparam logic [BYTE_W-1:0] CSI_ED   = "J";
    localparam logic [BYTE_W-1:0] CSI_EL   = "K";
    localparam logic [BYTE_W-1:0] CSI_SGR  = "m";

    // sequence phases
    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_CSI   = 2'd1;
    localparam logic [1:0] PH_OTHER = 2'd2;

    typedef struct packed {
        logic load;      // word accepted: capture it, start cell read
        logic exec;      // decode the fed byte
        logic nl;        // next line (may scroll)
        logic put;       // write character at cursor
        logic step;      // write one blank cell from the walker
        logic clear;     // arm walker for whole screen after reset
        logic out_load;  // load the result register
    } cmd_t;

    typedef struct packed {
        logic need_nl;
        logic need_put;
        logic blank_go;
        logic at_bottom;
        logic walk_done;
    } status_t;

    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [ROW_W-1:0] row,
        input logic [COL_W-1:0] col,
        input logic [ROW_W-1:0] top
    );
        logic [ROW_W:0] sum;
        sum = {1'b0, row} + {1'b0, top};
        if (sum >= (ROW_W+1)'(SCREEN_ROWS)) begin
            sum = sum - (ROW_W+1)'(SCREEN_ROWS);
        end
        return ADDR_W'(sum[ROW_W-1:0]) * ADDR_W'(SCREEN_COLS) + ADDR_W'(col);
    endfunction

endpackage

// ----- hdl/atte_ctrl.sv -----
// ----------------------------------------------------------------------------
// atte_ctrl
// Sequencer: handshakes, screen clearing after reset and the order of the
// line feed, blank walk, character write and result steps.
// ----------------------------------------------------------------------------
module atte_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_opcode,
    output logic              m_valid,
    input  logic              m_ready,
    input  atte_pkg::status_t status,
    output atte_pkg::cmd_t    cmd
);
    import atte_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT, ST_CLEAR, ST_IDLE, ST_DECODE, ST_NL, ST_BLANK, ST_PUT, ST_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   put_pend_reg, put_pend_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign accept  = s_valid && s_ready;

    always_comb begin
        cmd           = '0;
        state_next    = state_reg;
        put_pend_next = put_pend_reg;
        m_valid_next  = (m_valid_reg && m_ready) ? 1'b0 : m_valid_reg;
        case (state_reg)
            ST_INIT: begin
                cmd.clear  = 1'b1;
                state_next = ST_CLEAR;
            end
            ST_CLEAR: begin
                cmd.step = 1'b1;
                if (status.walk_done) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                cmd.load = accept;
                if (accept) state_next = s_opcode ? ST_FIN : ST_DECODE;
            end
            ST_DECODE: begin
                cmd.exec      = 1'b1;
                put_pend_next = status.need_put;
                if (status.need_nl)       state_next = ST_NL;
                else if (status.blank_go) state_next = ST_BLANK;
                else if (status.need_put) state_next = ST_PUT;
                else                      state_next = ST_FIN;
            end
            ST_NL: begin
                cmd.nl = 1'b1;
                if (status.at_bottom) state_next = ST_BLANK;
                else if (put_pend_reg) state_next = ST_PUT;
                else                   state_next = ST_FIN;
            end
            ST_BLANK: begin
                cmd.step = 1'b1;
                if (status.walk_done) state_next = put_pend_reg ? ST_PUT : ST_FIN;
            end
            ST_PUT: begin
                cmd.put    = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.out_load = 1'b1;
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
            default: state_next = ST_INIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            put_pend_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            put_pend_reg <= put_pend_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    a_ready_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!m_valid_reg || m_ready))
        else $error("word accepted with no room for its result");

    a_fin_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN) |=> m_valid_reg)
        else $error("result not presented after finish");

    a_put_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PUT) |-> ($past(state_reg) == ST_DECODE ||
                                   $past(state_reg) == ST_NL ||
                                   $past(state_reg) == ST_BLANK))
        else $error("character write from unexpected step");

    a_clear_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> (!s_ready && !m_valid_reg))
        else $error("handshake active during screen clear");

endmodule

// ----- hdl/atte_datapath.sv -----
// ----------------------------------------------------------------------------
// atte_datapath
// Cursor, pen, escape parser, blank walker and the screen memory. The screen
// is a ring of rows: a scroll moves the top row pointer and blanks one row.
// ----------------------------------------------------------------------------
module atte_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  atte_pkg::cmd_t                   cmd,
    output atte_pkg::status_t                status,
    input  logic                             s_opcode,
    input  logic [atte_pkg::BYTE_W-1:0]      s_data_byte,
    input  logic [atte_pkg::ROW_W-1:0]       s_read_row,
    input  logic [atte_pkg::COL_W-1:0]       s_read_col,
    output logic [atte_pkg::BYTE_W-1:0]      m_cell_char,
    output logic [atte_pkg::COLOR_W-1:0]     m_cell_color,
    output logic                             m_cell_bold,
    output logic [atte_pkg::ROW_W-1:0]       m_cursor_row_out,
    output logic [atte_pkg::COL_W-1:0]       m_cursor_col_out,
    output logic                             m_escape_active
);
    import atte_pkg::*;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_ROWS - 1);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(SCREEN_COLS - 1);

    // captured word
    logic              op_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              inrange_reg;

    // terminal state
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   top_reg, top_next;
    logic [COLOR_W-1:0] color_reg, color_next;
    logic               bold_reg, bold_next;
    logic               inseq_reg, inseq_next;
    logic [1:0]         phase_reg, phase_next;
    logic [PC_W-1:0]    pcount_reg, pcount_next;
    logic [PARAM_W-1:0] acc_reg, acc_next;
    logic               seen_reg, seen_next;
    logic [PARAM_W-1:0] params_reg [MAX_PARAMS];
    logic               param_wr;
    logic [PARAM_W-1:0] param_wdata;

    // blank walker
    logic [ROW_W-1:0] walk_row_reg, walk_row_next;
    logic [COL_W-1:0] walk_col_reg, walk_col_next;
    logic             walk_full_reg, walk_full_next;

    // screen memory
    logic [CELL_W-1:0] mem [CELL_COUNT];
    logic [CELL_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] walk_addr;

    // decode helpers
    logic                 letter, is_digit;
    logic [PARAM_W+3:0]   acc_mul;
    logic [PARAM_W-1:0]   eff_param [MAX_PARAMS];
    logic [PC_W-1:0]      eff_cnt;
    logic [PARAM_W-1:0]   p0, p1, n;
    logic [PARAM_W:0]     sum_row, sum_col;
    logic [PARAM_W-1:0]   pos_r, pos_c;
    logic [COL_W:0]       tab_col;
    logic [COLOR_W-1:0]   sgr_color;
    logic                 sgr_bold;
    logic                 need_nl, need_put, blank_go;

    assign letter   = (byte_reg >= "A" && byte_reg <= "Z") ||
                      (byte_reg >= "a" && byte_reg <= "z");
    assign is_digit = (byte_reg >= BYTE_ZERO) && (byte_reg <= BYTE_NINE);
    assign acc_mul  = {4'd0, acc_reg} * (PARAM_W+4)'(10)
                    + (PARAM_W+4)'(byte_reg - BYTE_ZERO);

    // parameter list as it stands once a pending one is closed
    always_comb begin
        for (int i = 0; i < MAX_PARAMS; i++) begin
            eff_param[i] = (seen_reg && pcount_reg == PC_W'(i)) ? acc_reg : params_reg[i];
        end
        eff_cnt = pcount_reg + PC_W'(seen_reg && (pcount_reg < PC_W'(MAX_PARAMS)));
    end

    assign p0 = (eff_cnt != '0) ? eff_param[0] : '0;
    assign p1 = (eff_cnt > PC_W'(1)) ? eff_param[1] : '0;
    assign n  = (eff_cnt != '0) ? p0 : PARAM_W'(1);
    assign sum_row = {1'b0, n} + (PARAM_W+1)'(row_reg);
    assign sum_col = {1'b0, n} + (PARAM_W+1)'(col_reg);
    assign pos_r   = (p0 == '0) ? '0 : p0 - PARAM_W'(1);
    assign pos_c   = (p1 == '0) ? '0 : p1 - PARAM_W'(1);
    assign tab_col = ({1'b0, col_reg} | (COL_W+1)'(TAB_STOP - 1)) + (COL_W+1)'(1);

    always_comb begin
        sgr_color = color_reg;
        sgr_bold  = bold_reg;
        if (eff_cnt == '0) begin
            sgr_color = COLOR_WHITE;
            sgr_bold  = 1'b0;
        end
        for (int i = 0; i < MAX_PARAMS; i++) begin
            if (PC_W'(i) < eff_cnt) begin
                if (eff_param[i] == PARAM_W'(0)) begin
                    sgr_color = COLOR_WHITE;
                    sgr_bold  = 1'b0;
                end else if (eff_param[i] == PARAM_W'(1)) begin
                    sgr_bold = 1'b1;
                end else if (eff_param[i] >= PARAM_W'(30) && eff_param[i] <= PARAM_W'(37)) begin
                    sgr_color = COLOR_W'(eff_param[i] - PARAM_W'(30));
                end
            end
        end
    end

    always_comb begin
        row_next       = row_reg;
        col_next       = col_reg;
        top_next       = top_reg;
        color_next     = color_reg;
        bold_next      = bold_reg;
        inseq_next     = inseq_reg;
        phase_next     = phase_reg;
        pcount_next    = pcount_reg;
        acc_next       = acc_reg;
        seen_next      = seen_reg;
        walk_row_next  = walk_row_reg;
        walk_col_next  = walk_col_reg;
        walk_full_next = walk_full_reg;
        param_wr       = 1'b0;
        param_wdata    = seen_reg ? acc_reg : '0;
        need_nl        = 1'b0;
        need_put       = 1'b0;
        blank_go       = 1'b0;

        if (cmd.exec) begin
            if (byte_reg == BYTE_ESC) begin
                inseq_next  = 1'b1;
                phase_next  = PH_START;
                pcount_next = '0;
                acc_next    = '0;
                seen_next   = 1'b0;
            end else if (!inseq_reg) begin
                if (byte_reg == BYTE_LF) begin
                    need_nl = 1'b1;
                end else if (byte_reg == BYTE_CR) begin
                    col_next = '0;
                end else if (byte_reg == BYTE_BS) begin
                    if (col_reg != '0) col_next = col_reg - COL_W'(1);
                end else if (byte_reg == BYTE_HT) begin
                    if (tab_col >= (COL_W+1)'(SCREEN_COLS)) need_nl = 1'b1;
                    else col_next = tab_col[COL_W-1:0];
                end else if (byte_reg >= BYTE_SPACE && byte_reg <= BYTE_DEL) begin
                    need_put = 1'b1;
                    need_nl  = (col_reg >= COL_W'(SCREEN_COLS));
                end
            end else if (letter) begin
                if (phase_reg == PH_CSI) begin
                    case (byte_reg)
                        CSI_CUP, CSI_HVP: begin
                            row_next = (pos_r > PARAM_W'(LAST_ROW)) ? LAST_ROW
                                                                     : ROW_W'(pos_r);
                            col_next = (pos_c > PARAM_W'(LAST_COL)) ? LAST_COL
                                                                     : COL_W'(pos_c);
                        end
                        CSI_CUU: begin
                            row_next = (n >= PARAM_W'(row_reg)) ? '0
                                                                : row_reg - ROW_W'(n);
                        end
                        CSI_CUD: begin
                            row_next = (sum_row > (PARAM_W+1)'(LAST_ROW)) ? LAST_ROW
                                                                          : ROW_W'(sum_row);
                        end
                        CSI_CUF: begin
                            col_next = (sum_col > (PARAM_W+1)'(LAST_COL)) ? LAST_COL
                                                                          : COL_W'(sum_col);
                        end
                        CSI_CUB: begin
                            col_next = (n >= PARAM_W'(col_reg)) ? '0
                                                                : col_reg - COL_W'(n);
                        end
                        CSI_ED: begin
                            if (eff_cnt == '0 || p0 == '0) begin
                                walk_full_next = 1'b1;
                                if (col_reg < COL_W'(SCREEN_COLS)) begin
                                    walk_row_next = row_reg;
                                    walk_col_next = col_reg;
                                    blank_go      = 1'b1;
                                end else if (row_reg != LAST_ROW) begin
                                    // pending wrap: start on the next row
                                    walk_row_next = row_reg + ROW_W'(1);
                                    walk_col_next = '0;
                                    blank_go      = 1'b1;
                                end
                            end else if (p0 == PARAM_W'(2)) begin
                                row_next       = '0;
                                col_next       = '0;
                                walk_row_next  = '0;
                                walk_col_next  = '0;
                                walk_full_next = 1'b1;
                                blank_go       = 1'b1;
                            end
                        end
                        CSI_EL: begin
                            if ((eff_cnt == '0 || p0 == '0) &&
                                col_reg < COL_W'(SCREEN_COLS)) begin
                                walk_row_next  = row_reg;
                                walk_col_next  = col_reg;
                                walk_full_next = 1'b0;
                                blank_go       = 1'b1;
                            end
                        end
                        CSI_SGR: begin
                            color_next = sgr_color;
                            bold_next  = sgr_bold;
                        end
                        default: ;
                    endcase
                end
                inseq_next  = 1'b0;
                phase_next  = PH_START;
                pcount_next = '0;
                acc_next    = '0;
                seen_next   = 1'b0;
            end else begin
                case (phase_reg)
                    PH_START: phase_next = (byte_reg == BYTE_LBRK) ? PH_CSI : PH_OTHER;
                    PH_CSI: begin
                        if (byte_reg == BYTE_SEMI) begin
                            if (pcount_reg < PC_W'(MAX_PARAMS)) begin
                                param_wr    = 1'b1;
                                pcount_next = pcount_reg + PC_W'(1);
                            end
                            acc_next  = '0;
                            seen_next = 1'b0;
                        end else if (is_digit) begin
                            acc_next  = (acc_mul > (PARAM_W+4)'(PARAM_LIMIT))
                                      ? PARAM_W'(PARAM_LIMIT) : PARAM_W'(acc_mul);
                            seen_next = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end

        if (cmd.nl) begin
            col_next = '0;
            if (row_reg == LAST_ROW) begin
                top_next       = (top_reg == LAST_ROW) ? '0 : top_reg + ROW_W'(1);
                walk_row_next  = LAST_ROW;
                walk_col_next  = '0;
                walk_full_next = 1'b0;
            end else begin
                row_next = row_reg + ROW_W'(1);
            end
        end

        if (cmd.put) col_next = col_reg + COL_W'(1);

        if (cmd.clear) begin
            walk_row_next  = '0;
            walk_col_next  = '0;
            walk_full_next = 1'b1;
        end

        if (cmd.step) begin
            if (walk_col_reg == LAST_COL) begin
                walk_col_next = '0;
                walk_row_next = walk_row_reg + ROW_W'(1);
            end else begin
                walk_col_next = walk_col_reg + COL_W'(1);
            end
        end
    end

    assign status.need_nl   = need_nl;
    assign status.need_put  = need_put;
    assign status.blank_go  = blank_go;
    assign status.at_bottom = (row_reg == LAST_ROW);
    assign status.walk_done = (walk_col_reg == LAST_COL) &&
                              (!walk_full_reg || walk_row_reg == LAST_ROW);

    assign cur_addr  = cell_addr(row_reg, col_reg, top_reg);
    assign walk_addr = cell_addr(walk_row_reg, walk_col_reg, top_reg);
    assign rd_addr   = cell_addr(s_read_row, s_read_col, top_reg);
    assign mem_we    = cmd.put || cmd.step;
    assign mem_waddr = cmd.put ? cur_addr : walk_addr;
    assign mem_wdata = cmd.put ? {bold_reg, color_reg, byte_reg} : BLANK_CELL;

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (cmd.load) rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg    <= '0;
            col_reg    <= '0;
            top_reg    <= '0;
            color_reg  <= COLOR_WHITE;
            bold_reg   <= 1'b0;
            inseq_reg  <= 1'b0;
            phase_reg  <= PH_START;
            pcount_reg <= '0;
            acc_reg    <= '0;
            seen_reg   <= 1'b0;
        end else begin
            row_reg    <= row_next;
            col_reg    <= col_next;
            top_reg    <= top_next;
            color_reg  <= color_next;
            bold_reg   <= bold_next;
            inseq_reg  <= inseq_next;
            phase_reg  <= phase_next;
            pcount_reg <= pcount_next;
            acc_reg    <= acc_next;
            seen_reg   <= seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        walk_row_reg  <= walk_row_next;
        walk_col_reg  <= walk_col_next;
        walk_full_reg <= walk_full_next;
        if (param_wr) params_reg[pcount_reg[PI_W-1:0]] <= param_wdata;
        if (cmd.load) begin
            op_reg      <= s_opcode;
            byte_reg    <= s_data_byte;
            inrange_reg <= (s_read_row < ROW_W'(SCREEN_ROWS)) &&
                           (s_read_col < COL_W'(SCREEN_COLS));
        end
        if (cmd.out_load) begin
            if (op_reg && inrange_reg) begin
                m_cell_char  <= rd_data_reg[BYTE_W-1:0];
                m_cell_color <= rd_data_reg[BYTE_W +: COLOR_W];
                m_cell_bold  <= rd_data_reg[CELL_W-1];
            end else begin
                m_cell_char  <= '0;
                m_cell_color <= '0;
                m_cell_bold  <= 1'b0;
            end
            m_cursor_row_out <= row_reg;
            m_cursor_col_out <= col_reg;
            m_escape_active  <= inseq_reg;
        end
    end

endmodule

// ----- hdl/ansi_text_terminal_engine.sv -----
// ----------------------------------------------------------------------------
// ansi_text_terminal_engine
// Text screen with cursor, fed by terminal output bytes; cells read back.
// ----------------------------------------------------------------------------
// Input words (s_valid/s_ready) carry an opcode: 0 feeds s_data_byte to the
// terminal, 1 reads the cell at s_read_row/s_read_col. Every word gives one
// result word (m_valid/m_ready) with the cell (zero for a feed), the cursor
// after the word and the escape flag.
// Steps: a read goes from acceptance straight to the result step, any other
// byte through a decode step first. A printable byte adds the cell write; a
// line feed adds a line step (a wrapping printable byte adds both). A scroll
// moves a row pointer and blanks one row. Erase line walks the rest of the
// row, erase display the rest of the screen (all of it for parameter 2), one
// cell per cycle through the single write port of the screen memory.
// s_ready stays low from acceptance until the result is presented, so no
// new word is taken before the last result is out.
// Reset clears the controller and the terminal state, then blanks the
// screen one cell per cycle before s_ready first rises.
// A stalled result holds; a new word is taken only while idle and when the
// result register is empty or being emptied in the same cycle.
module ansi_text_terminal_engine (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_opcode,
    input  logic [atte_pkg::BYTE_W-1:0]      s_data_byte,
    input  logic [atte_pkg::ROW_W-1:0]       s_read_row,
    input  logic [atte_pkg::COL_W-1:0]       s_read_col,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [atte_pkg::BYTE_W-1:0]      m_cell_char,
    output logic [atte_pkg::COLOR_W-1:0]     m_cell_color,
    output logic                             m_cell_bold,
    output logic [atte_pkg::ROW_W-1:0]       m_cursor_row_out,
    output logic [atte_pkg::COL_W-1:0]       m_cursor_col_out,
    output logic                             m_escape_active
);
    import atte_pkg::*;

    cmd_t    cmd;
    status_t status;

    atte_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_opcode),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .status   (status),
        .cmd      (cmd)
    );

    atte_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_opcode         (s_opcode),
        .s_data_byte      (s_data_byte),
        .s_read_row       (s_read_row),
        .s_read_col       (s_read_col),
        .m_cell_char      (m_cell_char),
        .m_cell_color     (m_cell_color),
        .m_cell_bold      (m_cell_bold),
        .m_cursor_row_out (m_cursor_row_out),
        .m_cursor_col_out (m_cursor_col_out),
        .m_escape_active  (m_escape_active)
    );

endmodule
